// ===== src/crtp_pkg.sv =====
// ----------------------------------------------------------------------------
// crtp_pkg
// Shared constants and types for the coordinate range text parser.
// ----------------------------------------------------------------------------
package crtp_pkg;

	localparam int DEFAULT_VALUE_WIDTH = 32;

	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_COMMA = 8'h2c;
	localparam logic [7:0] CHR_DOT   = 8'h2e;
	localparam logic [7:0] CHR_PLUS  = 8'h2b;
	localparam logic [7:0] CHR_DASH  = 8'h2d;

	localparam int NUM_LANES = 3;
	localparam int LANE_DOT  = 0;
	localparam int LANE_PLUS = 1;
	localparam int LANE_DASH = 2;

	localparam logic [7:0] SEP_CHARS [NUM_LANES] = '{CHR_DOT, CHR_PLUS, CHR_DASH};

	localparam logic [1:0] POS_MAX = 2'd3;

	typedef enum logic [2:0] {
		FORM_INVALID    = 3'd0,
		FORM_SINGLE     = 3'd1,
		FORM_DOTS       = 3'd2,
		FORM_PLUS       = 3'd3,
		FORM_PLUS_MINUS = 3'd4,
		FORM_DASH       = 3'd5
	} form_t;

	typedef struct packed {
		logic       seen;
		logic       run;
		logic [1:0] pos;
		logic [1:0] bad;
		logic       lead;
	} lane_flags_t;

	localparam lane_flags_t LANE_FLAGS_RESET = '{
		seen: 1'b0, run: 1'b1, pos: 2'd0, bad: 2'd0, lead: 1'b0
	};

endpackage

// ===== src/crtp_lane.sv =====
// ----------------------------------------------------------------------------
// crtp_lane
// Tokenizer for one candidate separator: splits the text into tokens at runs
// of the separator and accumulates the first two tokens as decimal numbers.
// ----------------------------------------------------------------------------
module crtp_lane import crtp_pkg::*; #(
	parameter int         VALUE_WIDTH   = DEFAULT_VALUE_WIDTH,
	parameter logic [7:0] SEP_CHAR      = CHR_DOT,
	parameter bit         LEAD_MINUS_EN = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   clr,
	input  logic [7:0]             text_byte,
	output lane_flags_t            flags_nxt,
	output logic [VALUE_WIDTH-1:0] first_nxt,
	output logic [VALUE_WIDTH-1:0] second_nxt
);

	lane_flags_t            flags_q;
	logic [VALUE_WIDTH-1:0] first_q;
	logic [VALUE_WIDTH-1:0] second_q;
	logic                   is_digit;
	logic [VALUE_WIDTH-1:0] digit_ext;

	assign is_digit  = (text_byte >= CHR_ZERO) && (text_byte <= CHR_NINE);
	assign digit_ext = {{(VALUE_WIDTH-4){1'b0}}, 4'(text_byte - CHR_ZERO)};

	always_comb begin
		logic skip;
		skip       = 1'b0;
		flags_nxt  = flags_q;
		first_nxt  = first_q;
		second_nxt = second_q;
		if (text_byte == SEP_CHAR) begin
			flags_nxt.run  = 1'b1;
			flags_nxt.seen = 1'b1;
		end else begin
			if (flags_q.run) begin
				flags_nxt.run = 1'b0;
				if (flags_q.pos != POS_MAX) begin
					flags_nxt.pos = flags_q.pos + 2'd1;
				end
				if (LEAD_MINUS_EN && flags_nxt.pos == 2'd2 && text_byte == CHR_DASH) begin
					flags_nxt.lead = 1'b1;
					skip           = 1'b1;
				end
			end
			if (!skip && (flags_nxt.pos == 2'd1 || flags_nxt.pos == 2'd2)) begin
				priority if (text_byte == CHR_COMMA) begin
				end else if (is_digit) begin
					if (flags_nxt.pos == 2'd1) begin
						first_nxt = (first_q << 3) + (first_q << 1) + digit_ext;
					end else begin
						second_nxt = (second_q << 3) + (second_q << 1) + digit_ext;
					end
				end else begin
					if (flags_nxt.pos == 2'd1) begin
						flags_nxt.bad[0] = 1'b1;
					end else begin
						flags_nxt.bad[1] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q  <= LANE_FLAGS_RESET;
			first_q  <= '0;
			second_q <= '0;
		end else if (en) begin
			if (clr) begin
				flags_q  <= LANE_FLAGS_RESET;
				first_q  <= '0;
				second_q <= '0;
			end else begin
				flags_q  <= flags_nxt;
				first_q  <= first_nxt;
				second_q <= second_nxt;
			end
		end
	end

endmodule

// ===== src/crtp_result.sv =====
// ----------------------------------------------------------------------------
// crtp_result
// Decodes the final accumulator snapshot of one text into form, start,
// length and strand.
// ----------------------------------------------------------------------------
module crtp_result import crtp_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic [VALUE_WIDTH-1:0] whole_value,
	input  logic                   whole_bad,
	input  lane_flags_t            flags      [NUM_LANES],
	input  logic [VALUE_WIDTH-1:0] first_val  [NUM_LANES],
	input  logic [VALUE_WIDTH-1:0] second_val [NUM_LANES],
	output form_t                  form_code,
	output logic [31:0]            start_offset,
	output logic [31:0]            span_length,
	output logic                   reverse_strand
);

	localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1);

	logic [VALUE_WIDTH-1:0] a;
	logic [VALUE_WIDTH-1:0] b;
	lane_flags_t            f;
	logic                   any_sep;
	logic                   is_plus;
	logic                   is_dot;

	always_comb begin
		is_plus = 1'b0;
		is_dot  = 1'b0;
		any_sep = 1'b1;
		priority if (flags[LANE_DOT].seen) begin
			f      = flags[LANE_DOT];
			a      = first_val[LANE_DOT];
			b      = second_val[LANE_DOT];
			is_dot = 1'b1;
		end else if (flags[LANE_PLUS].seen) begin
			f       = flags[LANE_PLUS];
			a       = first_val[LANE_PLUS];
			b       = second_val[LANE_PLUS];
			is_plus = 1'b1;
		end else begin
			f       = flags[LANE_DASH];
			a       = first_val[LANE_DASH];
			b       = second_val[LANE_DASH];
			any_sep = flags[LANE_DASH].seen;
		end
	end

	always_comb begin
		form_code      = FORM_INVALID;
		start_offset   = '0;
		span_length    = '0;
		reverse_strand = 1'b0;
		if (!whole_bad) begin
			form_code    = FORM_SINGLE;
			start_offset = 32'(whole_value - ONE);
			span_length  = 32'd1;
		end else if (any_sep && f.pos >= 2'd2 && f.bad == 2'b00) begin
			if (is_plus) begin
				span_length = 32'(b);
				if (f.lead) begin
					form_code      = FORM_PLUS_MINUS;
					start_offset   = 32'(a - b);
					reverse_strand = 1'b1;
				end else begin
					form_code    = FORM_PLUS;
					start_offset = 32'(a - ONE);
				end
			end else begin
				form_code = is_dot ? FORM_DOTS : FORM_DASH;
				if (a <= b) begin
					start_offset = 32'(a - ONE);
					span_length  = 32'(b - a + ONE);
				end else begin
					start_offset   = 32'(b - ONE);
					span_length    = 32'(a - b + ONE);
					reverse_strand = 1'b1;
				end
			end
		end
	end

endmodule

// ===== src/coordinate_range_text_parser_top.sv =====
// ----------------------------------------------------------------------------
// coordinate_range_text_parser_top
// Parses coordinate text, one character per beat, into a zero-based range.
// ----------------------------------------------------------------------------
// One character is taken every cycle with no gaps, texts back to back,
// unless ready is held low as below. A text's result leaves through the
// input register, the snapshot register of the final accumulators and the
// output register. The per-character path is the multiply-by-ten accumulate
// in each separator lane; the range decode (compare, subtract) reads the snapshot.
// The slave side holds ready low only while a finished result waits in the
// output register and the snapshot and input registers both hold a text end.
module coordinate_range_text_parser_top import crtp_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // text_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // start_offset[31:0], span_length[63:32]
	output logic [3:0]  m_tuser    // form_code[2:0], reverse_strand[3]
);

	localparam logic [VALUE_WIDTH-1:0] WHOLE_RESET = '0;

	logic                   v_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   v_s2;
	logic                   s1_go;
	logic                   s2_go;
	logic                   s2_free;
	logic                   out_free;

	logic [VALUE_WIDTH-1:0] whole_q;
	logic                   whole_bad_q;
	logic [VALUE_WIDTH-1:0] whole_nxt;
	logic                   whole_bad_nxt;
	logic                   is_digit;

	lane_flags_t            flags_nxt  [NUM_LANES];
	logic [VALUE_WIDTH-1:0] first_nxt  [NUM_LANES];
	logic [VALUE_WIDTH-1:0] second_nxt [NUM_LANES];

	logic [VALUE_WIDTH-1:0] whole_s2;
	logic                   whole_bad_s2;
	lane_flags_t            flags_s2   [NUM_LANES];
	logic [VALUE_WIDTH-1:0] first_s2   [NUM_LANES];
	logic [VALUE_WIDTH-1:0] second_s2  [NUM_LANES];

	form_t                  res_form;
	logic [31:0]            res_start;
	logic [31:0]            res_span;
	logic                   res_rev;

	// flow control
	assign out_free = !m_tvalid || m_tready;
	assign s2_go    = v_s2 && out_free;
	assign s2_free  = !v_s2 || s2_go;
	assign s1_go    = v_s1 && (!last_s1 || s2_free);
	assign s_tready = !v_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// whole-text single number
	assign is_digit = (byte_s1 >= CHR_ZERO) && (byte_s1 <= CHR_NINE);

	always_comb begin
		whole_nxt     = whole_q;
		whole_bad_nxt = whole_bad_q;
		priority if (byte_s1 == CHR_COMMA) begin
		end else if (is_digit) begin
			whole_nxt = (whole_q << 3) + (whole_q << 1)
				+ {{(VALUE_WIDTH-4){1'b0}}, 4'(byte_s1 - CHR_ZERO)};
		end else begin
			whole_bad_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q     <= WHOLE_RESET;
			whole_bad_q <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				whole_q     <= WHOLE_RESET;
				whole_bad_q <= 1'b0;
			end else begin
				whole_q     <= whole_nxt;
				whole_bad_q <= whole_bad_nxt;
			end
		end
	end

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		crtp_lane #(
			.VALUE_WIDTH  (VALUE_WIDTH),
			.SEP_CHAR     (SEP_CHARS[g]),
			.LEAD_MINUS_EN(g == LANE_PLUS)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (s1_go),
			.clr       (last_s1),
			.text_byte (byte_s1),
			.flags_nxt (flags_nxt[g]),
			.first_nxt (first_nxt[g]),
			.second_nxt(second_nxt[g])
		);
	end

	// snapshot of the final accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_free) begin
			v_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			whole_s2     <= whole_nxt;
			whole_bad_s2 <= whole_bad_nxt;
			flags_s2     <= flags_nxt;
			first_s2     <= first_nxt;
			second_s2    <= second_nxt;
		end
	end

	crtp_result #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_result (
		.whole_value   (whole_s2),
		.whole_bad     (whole_bad_s2),
		.flags         (flags_s2),
		.first_val     (first_s2),
		.second_val    (second_s2),
		.form_code     (res_form),
		.start_offset  (res_start),
		.span_length   (res_span),
		.reverse_strand(res_rev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_free) begin
			m_tvalid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			m_tdata <= {res_span, res_start};
			m_tuser <= {res_rev, 3'(res_form)};
		end
	end

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == FORM_INVALID |-> m_tdata == '0 && !m_tuser[3])
		else $error("invalid form with nonzero payload");

	a_single_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == FORM_SINGLE |-> m_tdata[63:32] == 32'd1 && !m_tuser[3])
		else $error("single number without unit length");

	a_plus_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2:0] == FORM_PLUS |-> !m_tuser[3])
		else $error("plus form on reverse strand");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && last_s1 && v_s2 && m_tvalid && !m_tready)
		else $error("input stalled without a full pipeline");

	a_snapshot_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_free |=> v_s2 && $stable(whole_bad_s2))
		else $error("snapshot lost while output stalled");

endmodule
